[sv/kat_pkg.sv]
`timescale 1ns / 1ps
// kat_pkg: shared types and constants for the key allowlist table
// depends on nothing; used by kat_ctrl and key_allowlist_table

package kat_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int KEY_BYTES       = 32;
    localparam int KEY_BITS        = KEY_BYTES * 8;
    localparam int INDEX_OUT_W     = 4;
    localparam int COUNT_OUT_W     = 5;

    // command codes; code 3 does nothing
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } kat_state_t;

    typedef struct packed {
        logic rd_en;      // key ram read issued this cycle
        logic cmp_valid;  // ram read data valid for compare this cycle
        logic finish;     // scan complete, commit and report
    } kat_ctrl_t;

endpackage

[sv/kat_ram.sv]
`timescale 1ns / 1ps
// kat_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing

module kat_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/kat_ctrl.sv]
`timescale 1ns / 1ps
// kat_ctrl: command sequencer, walks the key ram one slot per cycle
// depends on kat_pkg

module kat_ctrl #(
    parameter int ENTRIES = kat_pkg::ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    output logic                       busy,
    output kat_pkg::kat_ctrl_t         ctrl,
    output logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic [$clog2(ENTRIES)-1:0] cmp_idx
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    kat_pkg::kat_state_t state_reg, state_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kat_pkg::ST_IDLE:   if (go) state_next = kat_pkg::ST_SCAN;
            kat_pkg::ST_SCAN:   if (ptr_reg == LAST_IDX) state_next = kat_pkg::ST_DRAIN;
            kat_pkg::ST_DRAIN:  state_next = kat_pkg::ST_FINISH;
            kat_pkg::ST_FINISH: state_next = kat_pkg::ST_IDLE;
            default:            state_next = kat_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != kat_pkg::ST_IDLE);
        ctrl.rd_en  = (state_reg == kat_pkg::ST_SCAN);
        ctrl.finish = (state_reg == kat_pkg::ST_FINISH);
        ctrl.cmp_valid = cmp_valid_reg;
        ptr_next    = (state_reg == kat_pkg::ST_SCAN) ? ptr_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kat_pkg::ST_IDLE;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cmp_valid_reg <= ctrl.rd_en;
        end
    end

    // slot index is registered alongside the read data, so the two stay aligned
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= ptr_reg;
    end

    assign rd_addr = ptr_reg;
    assign cmp_idx = cmp_idx_reg;

endmodule

[sv/key_allowlist_table.sv]
`timescale 1ns / 1ps
// key_allowlist_table: allowlist of 256-bit keys with used and admin marks
// depends on kat_pkg, kat_ram, kat_ctrl
//
//  channel   | handshake          | fields
//  ----------+--------------------+-------------------------------------------------
//  command   | start, busy        | func, key_word0..3, admin_flag, prefix_bytes
//  result    | done (one cycle)   | hit, entry_index, is_admin, success, removed_count
//
// the key ram is read once per slot and each read is compared in the cycle after
// it is issued. done pulses for one cycle after the scan; busy drops in that same
// cycle, so the next transaction can be taken while the result is shown. the
// receiver cannot stall. reset clears all used and admin marks at once; key ram
// contents are left as is.

module key_allowlist_table #(
    parameter int ENTRIES = kat_pkg::ENTRIES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic [63:0]                     key_word0,
    input  logic [63:0]                     key_word1,
    input  logic [63:0]                     key_word2,
    input  logic [63:0]                     key_word3,
    input  logic                            admin_flag,
    input  logic [5:0]                      prefix_bytes,
    output logic                            done,
    output logic                            hit,
    output logic [kat_pkg::INDEX_OUT_W-1:0] entry_index,
    output logic                            is_admin,
    output logic                            success,
    output logic [kat_pkg::COUNT_OUT_W-1:0] removed_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KB    = kat_pkg::KEY_BITS;

    kat_pkg::kat_ctrl_t ctrl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   cmp_idx;
    logic [KB-1:0]      rdata;
    logic               go;
    logic               ram_we;

    logic [1:0]         func_reg;
    logic [KB-1:0]      key_reg;
    logic [KB-1:0]      mask_reg, mask_next;
    logic               admin_flag_reg;
    logic               del_ok_reg, del_ok_next;
    logic [ENTRIES-1:0] used_reg, used_next;
    logic [ENTRIES-1:0] admin_reg, admin_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic                            done_reg;
    logic                            hit_reg, hit_next;
    logic [kat_pkg::INDEX_OUT_W-1:0] index_reg, index_next;
    logic                            is_admin_reg, is_admin_next;
    logic                            success_reg, success_next;
    logic [kat_pkg::COUNT_OUT_W-1:0] removed_reg, removed_next;

    logic [5:0] cmp_len;
    logic       match;

    assign go = start && !busy;

    kat_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .busy    (busy),
        .ctrl    (ctrl),
        .rd_addr (rd_addr),
        .cmp_idx (cmp_idx)
    );

    kat_ram #(
        .WIDTH (KB),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (key_reg),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // byte mask, key byte 0 in the top byte; full key unless prefix delete
    always_comb
    begin
        cmp_len = (func == kat_pkg::FUNC_DELETE) ? prefix_bytes : 6'(kat_pkg::KEY_BYTES);
        for (int b = 0; b < kat_pkg::KEY_BYTES; b++)
        begin
            mask_next[KB-1-8*b -: 8] = (6'(b) < cmp_len) ? 8'hFF : 8'h00;
        end
        del_ok_next = (prefix_bytes != 6'd0) && (prefix_bytes <= 6'(kat_pkg::KEY_BYTES));
    end

    assign match = used_reg[cmp_idx] && (((rdata ^ key_reg) & mask_reg) == '0);

    assign ram_we = ctrl.finish && (func_reg == kat_pkg::FUNC_INSERT)
                    && !found_reg && free_found_reg;

    always_comb
    begin
        used_next       = used_reg;
        admin_next      = admin_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        index_next      = index_reg;
        is_admin_next   = is_admin_reg;
        success_next    = success_reg;
        removed_next    = removed_reg;

        if (go)
        begin
            found_next      = 1'b0;
            free_found_next = 1'b0;
            count_next      = '0;
        end

        if (ctrl.cmp_valid)
        begin
            if (match && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx;
            end
            if (!used_reg[cmp_idx] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx;
            end
            if ((func_reg == kat_pkg::FUNC_DELETE) && del_ok_reg && match)
            begin
                used_next[cmp_idx]  = 1'b0;
                admin_next[cmp_idx] = 1'b0;
                count_next          = count_reg + 1'b1;
            end
        end

        if (ctrl.finish)
        begin
            hit_next      = 1'b0;
            index_next    = '0;
            is_admin_next = 1'b0;
            success_next  = 1'b0;
            removed_next  = '0;
            unique case (func_reg)
                kat_pkg::FUNC_LOOKUP:
                begin
                    if (found_reg)
                    begin
                        hit_next      = 1'b1;
                        index_next    = kat_pkg::INDEX_OUT_W'(found_idx_reg);
                        is_admin_next = admin_reg[found_idx_reg];
                    end
                end
                kat_pkg::FUNC_INSERT:
                begin
                    priority if (found_reg)
                    begin
                        admin_next[found_idx_reg] = admin_flag_reg;
                        index_next   = kat_pkg::INDEX_OUT_W'(found_idx_reg);
                        success_next = 1'b1;
                    end
                    else if (free_found_reg)
                    begin
                        used_next[free_idx_reg]  = 1'b1;
                        admin_next[free_idx_reg] = admin_flag_reg;
                        index_next   = kat_pkg::INDEX_OUT_W'(free_idx_reg);
                        success_next = 1'b1;
                    end
                    else
                    begin
                        success_next = 1'b0;
                    end
                end
                kat_pkg::FUNC_DELETE:
                begin
                    removed_next = kat_pkg::COUNT_OUT_W'(count_reg);
                end
                default:
                begin
                    removed_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            admin_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            admin_reg      <= admin_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            count_reg      <= count_next;
            done_reg       <= ctrl.finish;
        end
    end

    // command capture and result payload
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            func_reg       <= func;
            key_reg        <= {key_word0, key_word1, key_word2, key_word3};
            mask_reg       <= mask_next;
            admin_flag_reg <= admin_flag;
            del_ok_reg     <= del_ok_next;
        end
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        hit_reg       <= hit_next;
        index_reg     <= index_next;
        is_admin_reg  <= is_admin_next;
        success_reg   <= success_next;
        removed_reg   <= removed_next;
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign entry_index   = index_reg;
    assign is_admin      = is_admin_reg;
    assign success       = success_reg;
    assign removed_count = removed_reg;

endmodule

[tb/sv/key_allowlist_table_tb.sv]
`timescale 1ns / 1ps
// key_allowlist_table_tb: self-checking bench for the key allowlist table
// depends on kat_pkg and key_allowlist_table; a tracker class predicts every reply

module key_allowlist_table_tb;

    localparam int         N_SLOTS        = kat_pkg::ENTRIES_DEFAULT;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         POOL_SIZE      = 32;
    localparam int         N_FAMILIES     = 4;
    localparam int         RANDOM_ITEMS   = 1620;
    localparam int         SETTLE_CYCLES  = 25;
    localparam int         WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic                            hit;
        logic [kat_pkg::INDEX_OUT_W-1:0] entry_index;
        logic                            is_admin;
        logic                            success;
        logic [kat_pkg::COUNT_OUT_W-1:0] removed_count;
    } reply_t;

    // mirror of the allowlist contents and the queue of replies it implies
    class allowlist_tracker;
        bit         slot_used [N_SLOTS];
        bit         slot_admin [N_SLOTS];
        bit [255:0] slot_key [N_SLOTS];
        reply_t     expected_replies [$];
        int         failures;

        function bit [255:0] prefix_mask(int nbytes);
            return ~({256{1'b1}} >> (8 * nbytes));
        endfunction

        function int find_key(bit [255:0] key);
            for (int s = 0; s < N_SLOTS; s++)
                if (slot_used[s] && slot_key[s] == key)
                    return s;
            return -1;
        endfunction

        function void note_command(logic [1:0] op, bit [255:0] key, bit admin,
                                   int unsigned plen);
            reply_t     r;
            int         s;
            bit [255:0] m;
            r = '0;
            case (op)
                kat_pkg::FUNC_LOOKUP:
                begin
                    s = find_key(key);
                    if (s >= 0)
                    begin
                        r.hit         = 1'b1;
                        r.entry_index = s[kat_pkg::INDEX_OUT_W-1:0];
                        r.is_admin    = slot_admin[s];
                    end
                end
                kat_pkg::FUNC_INSERT:
                begin
                    s = find_key(key);
                    if (s < 0)
                    begin
                        for (int i = 0; i < N_SLOTS && s < 0; i++)
                            if (!slot_used[i])
                                s = i;
                        if (s >= 0)
                        begin
                            slot_used[s] = 1'b1;
                            slot_key[s]  = key;
                        end
                    end
                    if (s >= 0)
                    begin
                        slot_admin[s] = admin;
                        r.entry_index = s[kat_pkg::INDEX_OUT_W-1:0];
                        r.success     = 1'b1;
                    end
                end
                kat_pkg::FUNC_DELETE:
                begin
                    if (plen >= 1 && plen <= kat_pkg::KEY_BYTES)
                    begin
                        m = prefix_mask(plen);
                        for (int i = 0; i < N_SLOTS; i++)
                            if (slot_used[i] && ((slot_key[i] ^ key) & m) == '0)
                            begin
                                slot_used[i]    = 1'b0;
                                slot_admin[i]   = 1'b0;
                                slot_key[i]     = '0;
                                r.removed_count = r.removed_count + 1'b1;
                            end
                    end
                end
                default: ;
            endcase
            expected_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [4:0] want, logic [4:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = expected_replies.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("entry_index", want.entry_index, got.entry_index);
            compare_field("is_admin", want.is_admin, got.is_admin);
            compare_field("success", want.success, got.success);
            compare_field("removed_count", want.removed_count, got.removed_count);
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [1:0]                      func;
    logic [63:0]                     key_word0;
    logic [63:0]                     key_word1;
    logic [63:0]                     key_word2;
    logic [63:0]                     key_word3;
    logic                            admin_flag;
    logic [5:0]                      prefix_bytes;
    logic                            done;
    logic                            hit;
    logic [kat_pkg::INDEX_OUT_W-1:0] entry_index;
    logic                            is_admin;
    logic                            success;
    logic [kat_pkg::COUNT_OUT_W-1:0] removed_count;

    allowlist_tracker sb;
    bit [255:0]       key_pool [POOL_SIZE];
    int               quiet_cycles = 0;

    key_allowlist_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .key_word0     (key_word0),
        .key_word1     (key_word1),
        .key_word2     (key_word2),
        .key_word3     (key_word3),
        .admin_flag    (admin_flag),
        .prefix_bytes  (prefix_bytes),
        .done          (done),
        .hit           (hit),
        .entry_index   (entry_index),
        .is_admin      (is_admin),
        .success       (success),
        .removed_count (removed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // the reply shown in a cycle belongs to an earlier transaction, so check first
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                sb.check_result(reply_t'({hit, entry_index, is_admin, success,
                                          removed_count}));
            if (start && !busy)
                sb.note_command(func, {key_word0, key_word1, key_word2, key_word3},
                                admin_flag, prefix_bytes);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("key_allowlist_table regression: fail");
                $finish;
            end
        end
    end

    function bit [255:0] rand_key();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task send_command(logic [1:0] op, bit [255:0] key, bit admin, bit [5:0] plen);
        @(negedge clk);
        func         <= op;
        key_word0    <= key[255:192];
        key_word1    <= key[191:128];
        key_word2    <= key[127:64];
        key_word3    <= key[63:0];
        admin_flag   <= admin;
        prefix_bytes <= plen;
        start        <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task drain_replies();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // keys come mostly from families sharing a leading run of bytes,
    // so prefix deletes hit several slots at once
    task build_key_pool();
        bit [255:0] bases [N_FAMILIES];
        bit [255:0] m;
        foreach (bases[f])
            bases[f] = rand_key();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            m = sb.prefix_mask($urandom_range(1, 31));
            key_pool[i] = (bases[i % N_FAMILIES] & m) | (rand_key() & ~m);
        end
    endtask

    task random_command(int deletes_pct);
        int         pick;
        int         r;
        int         b;
        bit [255:0] key;
        bit [5:0]   plen;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick >= 90)
            key = rand_key();
        else if (pick >= 80)
        begin
            // near miss: one bit away from a pooled key
            b      = $urandom_range(0, 255);
            key[b] = ~key[b];
        end
        r = $urandom_range(0, 99);
        if (r < deletes_pct)
            op = kat_pkg::FUNC_DELETE;
        else if (r < deletes_pct + 45)
            op = kat_pkg::FUNC_INSERT;
        else if (r < 96)
            op = kat_pkg::FUNC_LOOKUP;
        else
            op = FUNC_UNUSED;
        if (op == kat_pkg::FUNC_DELETE && $urandom_range(0, 99) < 88)
            plen = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(1, 4))
                                                : 6'($urandom_range(1, 32));
        else
            plen = 6'($urandom_range(0, 63));
        send_command(op, key, 1'($urandom_range(0, 1)), plen);
    endtask

    initial
    begin
        bit [255:0] k;
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = kat_pkg::FUNC_LOOKUP;
        key_word0    = '0;
        key_word1    = '0;
        key_word2    = '0;
        key_word3    = '0;
        admin_flag   = 1'b0;
        prefix_bytes = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, update of an existing key, unused code,
        // out-of-range prefix lengths, full table and a delete that frees all
        send_command(kat_pkg::FUNC_LOOKUP, '0, 1'b0, 6'd0);
        send_command(kat_pkg::FUNC_INSERT, '0, 1'b0, 6'd0);
        send_command(kat_pkg::FUNC_INSERT, '1, 1'b1, 6'd63);
        send_command(kat_pkg::FUNC_INSERT, '0, 1'b1, 6'd0);
        send_command(kat_pkg::FUNC_LOOKUP, '0, 1'b0, 6'd0);
        send_command(FUNC_UNUSED, '1, 1'b1, 6'd32);
        send_command(kat_pkg::FUNC_DELETE, '1, 1'b0, 6'd0);
        send_command(kat_pkg::FUNC_DELETE, '1, 1'b0, 6'd33);
        send_command(kat_pkg::FUNC_DELETE, '1, 1'b0, 6'd63);
        send_command(kat_pkg::FUNC_LOOKUP, '1, 1'b0, 6'd0);
        send_command(kat_pkg::FUNC_DELETE, '1, 1'b0, 6'd32);
        send_command(kat_pkg::FUNC_DELETE, '0, 1'b0, 6'd1);
        for (int i = 0; i < N_SLOTS; i++)
        begin
            k             = rand_key();
            k[255:248]    = 8'hA5;
            send_command(kat_pkg::FUNC_INSERT, k, i[0], 6'd0);
        end
        send_command(kat_pkg::FUNC_INSERT, rand_key(), 1'b1, 6'd0);
        k          = rand_key();
        k[255:248] = 8'hA5;
        send_command(kat_pkg::FUNC_DELETE, k, 1'b0, 6'd1);

        build_key_pool();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 400 == 0)
                drain_replies();
            if (!(n >= 700 && n < 1000) && $urandom_range(0, 99) < 30)
                hold_off($urandom_range(1, 40));
            // alternate fill-heavy and delete-heavy stretches
            random_command(((n / 150) % 2 == 1) ? 22 : 5);
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.expected_replies.size() == 0)
            $display("key_allowlist_table regression: pass");
        else
            $display("key_allowlist_table regression: fail");
        $finish;
    end

endmodule
